// ===== sv/dam3_pkg.sv =====
package dam3_pkg;

  // One input word
  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } in_t;

  // One result word
  typedef struct packed {
    logic signed [31:0] echo_value;
    logic               first_occurrence;
    logic               store_full;
    logic               answer_valid;
    logic               has_middle;
    logic signed [31:0] middle_value;
  } out_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_OUT
  } state_t;

  // Number of leading distinct values kept for the middle answer
  localparam int unsigned FIRST_N = 3;

  // Middle of three pairwise distinct signed values
  function automatic logic signed [31:0] middle_of(
    input logic signed [31:0] a,
    input logic signed [31:0] b,
    input logic signed [31:0] c
  );
    logic ab, bc, ac;
    ab = a < b;
    bc = b < c;
    ac = a < c;
    if (ab == bc) begin
      middle_of = b;
    end else if (ab != ac) begin
      middle_of = a;
    end else begin
      middle_of = c;
    end
  endfunction

endpackage

// ===== sv/dedup_and_middle_of_three_top.sv =====
// Order-preserving deduplication of a set of signed 32-bit words, one word per
// item, the set closed by a word with last set. Each word is checked against
// the distinct words already stored for the set by walking the store one entry
// a cycle through a single equality comparator; a new word is appended and
// flagged first_occurrence, a new word arriving with MAX_ITEMS entries stored
// is dropped and flagged store_full. The word with last also carries the
// middle of the first three distinct words of the set (has_middle low and
// middle_value zero when fewer than three were seen), and the store is then
// emptied. One word is in work at a time: an accepted word goes through a
// scan of the stored entries (skipped with the store empty, cut short on a
// repeat), a decide state and an output state; the next word is taken once
// the sequencer is back in idle. The serial store scan sets how long an item
// takes. No clearing pass is needed after reset. The result sits in an output
// register, so the next word is accepted while a result waits.
module dedup_and_middle_of_three_top #(
  parameter int unsigned MAX_ITEMS = 1024
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  dam3_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output dam3_pkg::out_t out_data
);

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  dam3_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic             pend_r, pend_nxt;
  logic             seen_r, seen_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic signed [31:0] value_r, value_nxt;
  logic               last_r, last_nxt;
  logic               first_r, first_nxt;
  logic               full_r, full_nxt;
  logic               hasmid_r, hasmid_nxt;
  logic signed [31:0] first3_r [dam3_pkg::FIRST_N];
  logic signed [31:0] first3_nxt [dam3_pkg::FIRST_N];
  dam3_pkg::out_t     out_r, out_nxt;

  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_raddr;
  logic [31:0]    ram_rdata;
  logic           accept;
  logic           hit;
  logic [CW-1:0]  count_inc;

  // Distinct value store
  dam3_ram #(
    .WIDTH (32),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (value_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != dam3_pkg::ST_IDLE);
  assign hit       = pend_r && (ram_rdata == value_r);
  assign ram_raddr = idx_r[AW-1:0];
  assign count_inc = count_r + CW'(1);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Sequencer: scan, decide, hand off
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pend_nxt      = 1'b0;
    seen_nxt      = seen_r;
    out_valid_nxt = out_valid_r && out_stall;
    value_nxt     = value_r;
    last_nxt      = last_r;
    first_nxt     = first_r;
    full_nxt      = full_r;
    hasmid_nxt    = hasmid_r;
    first3_nxt    = first3_r;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    unique case (state_r)
      dam3_pkg::ST_IDLE: begin
        if (accept) begin
          value_nxt = in_data.value;
          last_nxt  = in_data.last;
          idx_nxt   = '0;
          seen_nxt  = 1'b0;
          state_nxt = (count_r == '0) ? dam3_pkg::ST_DECIDE : dam3_pkg::ST_SCAN;
        end
      end
      dam3_pkg::ST_SCAN: begin
        // compare last fetched entry, fetch the next one
        if (hit) begin
          seen_nxt  = 1'b1;
          state_nxt = dam3_pkg::ST_DECIDE;
        end else if (idx_r >= count_r) begin
          state_nxt = dam3_pkg::ST_DECIDE;
        end else begin
          ram_re   = 1'b1;
          pend_nxt = 1'b1;
          idx_nxt  = idx_r + CW'(1);
        end
      end
      dam3_pkg::ST_DECIDE: begin
        first_nxt  = 1'b0;
        full_nxt   = 1'b0;
        hasmid_nxt = (count_r >= CW'(dam3_pkg::FIRST_N));
        if (!seen_r) begin
          if (count_r < CW'(MAX_ITEMS)) begin
            ram_we    = 1'b1;
            first_nxt = 1'b1;
            count_nxt = count_inc;
            hasmid_nxt = (count_inc >= CW'(dam3_pkg::FIRST_N));
            if (count_r < CW'(dam3_pkg::FIRST_N)) begin
              first3_nxt[count_r[1:0]] = value_r;
            end
          end else begin
            full_nxt = 1'b1;
          end
        end
        if (last_r) begin
          count_nxt = '0;
        end
        state_nxt = dam3_pkg::ST_OUT;
      end
      dam3_pkg::ST_OUT: begin
        // load the output register once it is free
        if (!out_valid_r || !out_stall) begin
          out_nxt.echo_value       = value_r;
          out_nxt.first_occurrence = first_r;
          out_nxt.store_full       = full_r;
          out_nxt.answer_valid     = last_r;
          out_nxt.has_middle       = last_r && hasmid_r;
          out_nxt.middle_value     = (last_r && hasmid_r) ?
              dam3_pkg::middle_of(first3_r[0], first3_r[1], first3_r[2]) : '0;
          out_valid_nxt            = 1'b1;
          state_nxt                = dam3_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dam3_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dam3_pkg::ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    value_r  <= value_nxt;
    last_r   <= last_nxt;
    first_r  <= first_nxt;
    full_r   <= full_nxt;
    hasmid_r <= hasmid_nxt;
    first3_r <= first3_nxt;
    out_r    <= out_nxt;
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ITEMS))
    else $error("distinct count beyond store depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != dam3_pkg::ST_IDLE))
    else $error("sequencer idle right after accepting a word");

  a_first_or_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.first_occurrence && out_r.store_full))
    else $error("result both stored and dropped");

  a_no_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.answer_valid) |->
      (!out_r.has_middle && (out_r.middle_value == '0)))
    else $error("middle answer on a word without last");

endmodule

// ===== sv/dam3_ram.sv =====
module dam3_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned STORE_DEPTH = 1024;
  localparam logic [31:0] MOST_NEG    = 32'h8000_0000;
  localparam logic [31:0] MOST_POS    = 32'h7fff_ffff;
  localparam int          CALM_TAIL   = 40;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  dam3_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  dam3_pkg::out_t out_data;

  dedup_and_middle_of_three_top #(
    .MAX_ITEMS(STORE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // words waiting to be sent and results waiting to come back
  dam3_pkg::in_t  pending_words[$];
  dam3_pkg::out_t expected_results[$];
  int   total_words = 32'h7fff_ffff;
  int   words_taken = 0;
  int   mismatches = 0;
  bit   word_taken = 1'b0;
  bit   calm = 1'b0;
  bit   hush = 1'b0;
  int   gap_left = 0;
  int   stall_left = 0;

  // predictor state: distinct words of the current set, in arrival order
  logic signed [31:0] seen_words[STORE_DEPTH];
  int unsigned        seen_count = 0;

  function automatic logic signed [31:0] middle_of_three(
    input logic signed [31:0] a,
    input logic signed [31:0] b,
    input logic signed [31:0] c
  );
    if (a < b) begin
      return (b < c) ? b : ((a < c) ? c : a);
    end else begin
      return (a < c) ? a : ((b < c) ? c : b);
    end
  endfunction

  // expected result for one accepted word; updates the distinct-word store
  function automatic dam3_pkg::out_t dedup_predict(input dam3_pkg::in_t w);
    dam3_pkg::out_t r;
    bit   hit;
    int   k;
    r = '0;
    hit = 1'b0;
    r.echo_value = w.value;
    for (k = 0; k < seen_count; k++) begin
      if (seen_words[k] == w.value) begin
        hit = 1'b1;
        break;
      end
    end
    if (!hit) begin
      if (seen_count < STORE_DEPTH) begin
        seen_words[seen_count] = w.value;
        seen_count++;
        r.first_occurrence = 1'b1;
      end else begin
        r.store_full = 1'b1;
      end
    end
    if (w.last) begin
      r.answer_valid = 1'b1;
      if (seen_count >= 3) begin
        r.has_middle   = 1'b1;
        r.middle_value = middle_of_three(seen_words[0], seen_words[1], seen_words[2]);
      end
      seen_count = 0;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      mismatches++;
    end
  endtask

  // sample both handshakes at the rising edge
  always @(posedge clk) begin
    dam3_pkg::out_t want;
    calm = (words_taken + CALM_TAIL >= total_words);
    if (rst_n && in_valid && !in_stall) begin
      word_taken = 1'b1;
      words_taken++;
      expected_results.push_back(dedup_predict(in_data));
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing pending: echo_value %0d",
               $signed(out_data.echo_value));
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("echo_value", want.echo_value, out_data.echo_value);
        check_field("first_occurrence", 32'(want.first_occurrence),
                    32'(out_data.first_occurrence));
        check_field("store_full", 32'(want.store_full), 32'(out_data.store_full));
        check_field("answer_valid", 32'(want.answer_valid),
                    32'(out_data.answer_valid));
        check_field("has_middle", 32'(want.has_middle), 32'(out_data.has_middle));
        check_field("middle_value", want.middle_value, out_data.middle_value);
      end
    end
  end

  // driver: next word from the queue, with random gaps between words
  always @(negedge clk) begin
    logic          nxt_valid;
    dam3_pkg::in_t nxt_data;
    nxt_valid = in_valid;
    nxt_data  = in_data;
    if (rst_n) begin
      if (in_valid && word_taken) begin
        nxt_valid = 1'b0;
      end
      word_taken = 1'b0;
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_words.size() > 0) begin
          nxt_data  = pending_words.pop_front();
          nxt_valid = 1'b1;
          if (!calm && !hush && $urandom_range(0, 4) == 0) begin
            gap_left = $urandom_range(1, 6);
          end
        end
      end
    end
    in_valid <= nxt_valid;
    in_data  <= nxt_data;
  end

  // result side backpressure in bursts; quiet spells come and go
  always @(negedge clk) begin
    logic nxt_stall;
    nxt_stall = 1'b0;
    if ($urandom_range(0, 199) == 0) begin
      hush = !hush;
    end
    if (stall_left > 0) begin
      nxt_stall = 1'b1;
      stall_left--;
    end else if (!calm && !hush && $urandom_range(0, 5) == 0) begin
      nxt_stall  = 1'b1;
      stall_left = $urandom_range(0, 5);
    end
    out_stall <= nxt_stall;
  end

  task automatic add_word(input logic [31:0] v, input bit lst);
    dam3_pkg::in_t w;
    w.value = v;
    w.last  = lst;
    pending_words.push_back(w);
  endtask

  // mostly interesting corners, otherwise anything
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return MOST_NEG;
      1:       return MOST_POS;
      2:       return '0;
      3:       return '1;
      4, 5:    return 32'($urandom_range(0, 16)) - 32'd8;
      default: return $urandom;
    endcase
  endfunction

  // a set drawn mostly from a small pool so repeats are common
  task automatic add_set(input int n);
    logic [31:0] pool[$];
    int          k;
    repeat ($urandom_range(1, 5)) pool.push_back(pick_value());
    for (k = 0; k < n; k++) begin
      add_word(($urandom_range(0, 2) == 0) ? pick_value()
                                           : pool[$urandom_range(0, pool.size() - 1)],
               k == n - 1);
    end
  endtask

  // fill the store completely, then push new words that must be dropped
  task automatic add_full_set();
    bit          used[logic [31:0]];
    logic [31:0] kept[$];
    logic [31:0] v;
    int          k;
    while (kept.size() < STORE_DEPTH) begin
      v = $urandom;
      if (!used.exists(v)) begin
        used[v] = 1'b1;
        kept.push_back(v);
        add_word(v, 1'b0);
        if ($urandom_range(0, 99) == 0) begin
          add_word(kept[$urandom_range(0, kept.size() - 1)], 1'b0);
        end
      end
    end
    for (k = 0; k < 4; k++) begin
      do v = $urandom; while (used.exists(v));
      add_word(v, 1'b0);
      add_word(kept[$urandom_range(0, STORE_DEPTH - 1)], 1'b0);
    end
    add_word(kept[0], 1'b0);
    add_word(kept[STORE_DEPTH - 1], 1'b0);
    // last word is new and gets dropped; the answer still comes
    do v = $urandom; while (used.exists(v));
    add_word(v, 1'b1);
  endtask

  initial begin
    int  random_words;
    int  n;
    bit  big_done;
    random_words = 0;
    big_done     = 1'b0;

    // extremes; last word is the third distinct one
    add_word(MOST_NEG, 1'b0);
    add_word(MOST_POS, 1'b0);
    add_word('0, 1'b1);
    // repeats between distinct words
    add_word(32'd5, 1'b0);
    add_word(32'd5, 1'b0);
    add_word(-32'sd5, 1'b0);
    add_word(32'd5, 1'b0);
    add_word(32'd7, 1'b1);
    // one distinct word only
    add_word('1, 1'b0);
    add_word('1, 1'b1);
    // lone last word
    add_word(MOST_POS, 1'b1);
    // two distinct words
    add_word(32'd1, 1'b0);
    add_word(32'd2, 1'b1);
    // last word is a repeat
    add_word(32'd3, 1'b0);
    add_word(32'd1, 1'b0);
    add_word(32'd2, 1'b0);
    add_word(32'd1, 1'b1);
    // signed ordering across zero
    add_word(32'd10, 1'b0);
    add_word(-32'sd10, 1'b0);
    add_word('0, 1'b1);

    // random sets, with one set that overflows the store halfway through
    while (random_words < 560) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      add_set(n);
      random_words += n;
      if (!big_done && random_words > 280) begin
        add_full_set();
        big_done = 1'b1;
      end
    end
    total_words = pending_words.size();

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    while (words_taken < total_words) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (STORE_DEPTH + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("** dedup_and_middle_of_three_top: PASSED **");
    end else begin
      $display("** dedup_and_middle_of_three_top: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #70_000_000;
    $display("** dedup_and_middle_of_three_top: FAILED **");
    $finish;
  end

endmodule
